[sv/block_entropy_variance_top_defines.svh]
// Assertion macros for the block entropy statistics block.
`ifndef BLOCK_ENTROPY_VARIANCE_TOP_DEFINES_SVH
`define BLOCK_ENTROPY_VARIANCE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEV_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BEV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/bev_pkg.sv]
`timescale 1ns / 1ps

package bev_pkg;

	localparam int unsigned BYTES_MAX = 65536;
	localparam int unsigned BLOCKS_MAX = 16777216;
	localparam int unsigned BINS = 256;

	localparam logic [16:0] CHUNK_LEN_RESET = 17'd2048;
	localparam logic [16:0] MAX_BLOCK_C = 17'(BYTES_MAX);
	localparam logic [24:0] MAX_BLOCKS_C = 25'(BLOCKS_MAX);
	localparam logic [20:0] ENTROPY_MAX = 21'(8 << 16);
	localparam logic [28:0] VARIANCE_MAX = 29'(1 << 28);

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last;
	} bev_req_t;

	typedef struct packed {
		logic [28:0] variance;
		logic [19:0] mean_entropy;
		logic [24:0] block_total;
		logic        overflow;
	} bev_res_t;

	function automatic logic [4:0] msb_pos(input logic [16:0] x);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (x[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

endpackage

[sv/block_entropy_variance_top.sv]
// A byte that does not close a block is counted into its bin. A block close walks all
// 256 bins, taking a log for each used bin, then divides and forms the block entropy;
// the last byte also forms the final statistics, and the result strobe follows.
// The block has one shared 32 by 32 multiplier and one bit-serial 65-step divider, and
// takes a new byte only while idle. Reset clears all accumulated state and sets the
// block length to 2048. The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`include "block_entropy_variance_top_defines.svh"

module block_entropy_variance_top
	import bev_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  bev_req_t    req,
	output logic        done,
	output bev_res_t    result,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_INC   = 5'd1;
	localparam logic [4:0] S_WRD   = 5'd2;
	localparam logic [4:0] S_WCHK  = 5'd3;
	localparam logic [4:0] S_LINIT = 5'd4;
	localparam logic [4:0] S_LMUL  = 5'd5;
	localparam logic [4:0] S_LNORM = 5'd6;
	localparam logic [4:0] S_CLMUL = 5'd7;
	localparam logic [4:0] S_CLACC = 5'd8;
	localparam logic [4:0] S_DIVS  = 5'd9;
	localparam logic [4:0] S_DIV   = 5'd10;
	localparam logic [4:0] S_LN    = 5'd11;
	localparam logic [4:0] S_H     = 5'd12;
	localparam logic [4:0] S_SQ    = 5'd13;
	localparam logic [4:0] S_ACC   = 5'd14;
	localparam logic [4:0] S_F0    = 5'd15;
	localparam logic [4:0] S_F1    = 5'd16;
	localparam logic [4:0] S_F2    = 5'd17;
	localparam logic [4:0] S_F3    = 5'd18;
	localparam logic [4:0] S_F4    = 5'd19;
	localparam logic [4:0] S_F5    = 5'd20;
	localparam logic [4:0] S_F6    = 5'd21;
	localparam logic [4:0] S_F7    = 5'd22;
	localparam logic [4:0] S_F8    = 5'd23;
	localparam logic [4:0] S_F9    = 5'd24;
	localparam logic [4:0] S_F10   = 5'd25;
	localparam logic [4:0] S_EMIT  = 5'd26;

	localparam logic RET_BIN = 1'b0;
	localparam logic RET_LEN = 1'b1;

	logic [4:0]  state_q;
	logic [16:0] chunk_len_q;
	logic [16:0] mem_q [BINS];
	logic [BINS-1:0] vld_q;
	logic [16:0] mem_rd_q;
	logic        vld_rd_q;
	logic [7:0]  rd_addr;
	logic        mem_we;
	logic [16:0] new_cnt;

	logic [7:0]  byte_q;
	logic        last_q;
	logic [16:0] bib_q;
	logic [24:0] blocks_q;
	logic [43:0] esum_q;
	logic [63:0] esq_q;
	logic        ovf_q;

	logic [7:0]  bin_q;
	logic [16:0] c_q;
	logic [16:0] x_q;
	logic [30:0] m_q;
	logic [20:0] lr_q;
	logic [4:0]  it_q;
	logic        log_ret_q;
	logic [39:0] s_q;
	logic [40:0] avg_q;
	logic [19:0] h_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_q;

	logic [64:0] dvd_q;
	logic [32:0] rem_q;
	logic [32:0] dvs_q;
	logic [6:0]  dcnt_q;
	logic [4:0]  div_ret_q;

	logic [19:0] q_q;
	logic [24:0] r_q;
	logic [39:0] qq_q;
	logic [63:0] acc_q;
	logic [63:0] d_q;
	logic [19:0] mean_q;
	logic [28:0] var_q;

	logic        done_q;
	bev_res_t    result_q;

	logic        whole;
	logic [16:0] eff;
	logic [16:0] new_bib;
	logic [33:0] rem_sh;
	logic        rem_ge;
	logic [33:0] rem_nx;
	logic [33:0] sq_t;
	logic [4:0]  lg_e;
	logic [20:0] h_diff;
	logic [63:0] sub1;
	logic [63:0] d_f9;
	logic [64:0] esq_sum;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign whole   = (chunk_len_q == 17'd0) || (chunk_len_q > MAX_BLOCK_C);
	assign eff     = whole ? MAX_BLOCK_C : chunk_len_q;
	assign new_bib = bib_q + 17'd1;
	assign new_cnt = (vld_rd_q ? mem_rd_q : 17'd0) + 17'd1;
	assign rd_addr = (state_q == S_IDLE) ? req.byte_value : bin_q;
	assign mem_we  = (state_q == S_INC);

	assign rem_sh = {rem_q, dvd_q[64]};
	assign rem_ge = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	assign sq_t   = prod_q[63:30];
	assign lg_e   = msb_pos(x_q);
	assign h_diff = lr_q - avg_q[20:0];

	assign sub1    = acc_q + {prod_q[43:0], 20'd0};
	assign d_f9    = (d_q > dvd_q[63:0]) ? (d_q - dvd_q[63:0]) : 64'd0;
	assign esq_sum = {1'b0, esq_q} + {1'b0, prod_q};

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (state_q)
			S_LMUL: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			S_CLMUL: begin
				mul_a = {15'd0, c_q};
				mul_b = {11'd0, lr_q};
			end
			S_SQ: begin
				mul_a = {12'd0, h_q};
				mul_b = {12'd0, h_q};
			end
			S_F2: begin
				mul_a = {12'd0, q_q};
				mul_b = {12'd0, q_q};
			end
			S_F4: begin
				mul_a = {12'd0, qq_q[19:0]};
				mul_b = {7'd0, blocks_q};
			end
			S_F5: begin
				mul_a = {12'd0, qq_q[39:20]};
				mul_b = {7'd0, blocks_q};
			end
			S_F6: begin
				mul_a = {11'd0, q_q, 1'b0};
				mul_b = {7'd0, r_q};
			end
			S_F7: begin
				mul_a = {7'd0, r_q};
				mul_b = {7'd0, r_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q   <= mul_a * mul_b;
		mem_rd_q <= mem_q[rd_addr];
		vld_rd_q <= vld_q[rd_addr];
		if (mem_we) begin
			mem_q[byte_q] <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chunk_len_q <= CHUNK_LEN_RESET;
			vld_q       <= '0;
			bib_q       <= 17'd0;
			blocks_q    <= 25'd0;
			esum_q      <= 44'd0;
			esq_q       <= 64'd0;
			ovf_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				chunk_len_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						byte_q  <= req.byte_value;
						last_q  <= req.last;
						state_q <= S_INC;
					end
				end
				S_INC: begin
					vld_q[byte_q] <= 1'b1;
					bib_q         <= new_bib;
					if (new_bib >= eff || last_q) begin
						if (new_bib >= eff && whole && !last_q) begin
							ovf_q <= 1'b1;
						end
						bin_q   <= 8'd0;
						s_q     <= 40'd0;
						state_q <= S_WRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (vld_rd_q && mem_rd_q != 17'd0) begin
						c_q       <= mem_rd_q;
						x_q       <= mem_rd_q;
						log_ret_q <= RET_BIN;
						state_q   <= S_LINIT;
					end else if (bin_q == 8'(BINS - 1)) begin
						state_q <= S_DIVS;
					end else begin
						bin_q   <= bin_q + 8'd1;
						state_q <= S_WRD;
					end
				end
				S_LINIT: begin
					m_q     <= 31'(x_q) << (5'd30 - lg_e);
					lr_q    <= {lg_e, 16'd0};
					it_q    <= 5'd16;
					state_q <= S_LMUL;
				end
				S_LMUL: begin
					state_q <= S_LNORM;
				end
				S_LNORM: begin
					if (sq_t[33:31] != 3'd0) begin
						m_q                   <= sq_t[31:1];
						lr_q[it_q - 5'd1]     <= 1'b1;
					end else begin
						m_q <= sq_t[30:0];
					end
					it_q <= it_q - 5'd1;
					if (it_q == 5'd1) begin
						state_q <= (log_ret_q == RET_BIN) ? S_CLMUL : S_H;
					end else begin
						state_q <= S_LMUL;
					end
				end
				S_CLMUL: begin
					state_q <= S_CLACC;
				end
				S_CLACC: begin
					s_q <= s_q + prod_q[39:0];
					if (bin_q == 8'(BINS - 1)) begin
						state_q <= S_DIVS;
					end else begin
						bin_q   <= bin_q + 8'd1;
						state_q <= S_WRD;
					end
				end
				S_DIVS: begin
					dvd_q     <= 65'(s_q) + 65'(bib_q >> 1);
					rem_q     <= 33'd0;
					dvs_q     <= 33'(bib_q);
					dcnt_q    <= 7'd65;
					div_ret_q <= S_LN;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					dvd_q  <= {dvd_q[63:0], rem_ge};
					rem_q  <= rem_nx[32:0];
					dcnt_q <= dcnt_q - 7'd1;
					if (dcnt_q == 7'd1) begin
						state_q <= div_ret_q;
					end
				end
				S_LN: begin
					avg_q     <= dvd_q[40:0];
					x_q       <= bib_q;
					log_ret_q <= RET_LEN;
					state_q   <= S_LINIT;
				end
				S_H: begin
					if (avg_q >= 41'(lr_q)) begin
						h_q <= 20'd0;
					end else if (h_diff > ENTROPY_MAX) begin
						h_q <= ENTROPY_MAX[19:0];
					end else begin
						h_q <= h_diff[19:0];
					end
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					vld_q <= '0;
					bib_q <= 17'd0;
					if (blocks_q >= MAX_BLOCKS_C) begin
						ovf_q <= 1'b1;
					end else begin
						blocks_q <= blocks_q + 25'd1;
						esum_q   <= esum_q + 44'(h_q);
						if (esq_sum[64]) begin
							esq_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							esq_q <= esq_sum[63:0];
						end
					end
					state_q <= last_q ? S_F0 : S_IDLE;
				end
				S_F0: begin
					if (blocks_q == 25'd0) begin
						var_q   <= 29'd0;
						mean_q  <= 20'd0;
						state_q <= S_EMIT;
					end else begin
						dvd_q     <= 65'(esum_q);
						rem_q     <= 33'd0;
						dvs_q     <= 33'(blocks_q);
						dcnt_q    <= 7'd65;
						div_ret_q <= S_F1;
						state_q   <= S_DIV;
					end
				end
				S_F1: begin
					q_q       <= dvd_q[19:0];
					r_q       <= rem_q[24:0];
					dvd_q     <= 65'(esum_q) + 65'(blocks_q >> 1);
					rem_q     <= 33'd0;
					dcnt_q    <= 7'd65;
					div_ret_q <= S_F2;
					state_q   <= S_DIV;
				end
				S_F2: begin
					mean_q  <= dvd_q[19:0];
					state_q <= S_F3;
				end
				S_F3: begin
					qq_q    <= prod_q[39:0];
					state_q <= S_F4;
				end
				S_F4: begin
					state_q <= S_F5;
				end
				S_F5: begin
					acc_q   <= prod_q;
					state_q <= S_F6;
				end
				S_F6: begin
					d_q     <= (esq_q > sub1) ? (esq_q - sub1) : 64'd0;
					state_q <= S_F7;
				end
				S_F7: begin
					d_q     <= (d_q > prod_q) ? (d_q - prod_q) : 64'd0;
					state_q <= S_F8;
				end
				S_F8: begin
					dvd_q     <= 65'(prod_q) + 65'(blocks_q >> 1);
					rem_q     <= 33'd0;
					dcnt_q    <= 7'd65;
					div_ret_q <= S_F9;
					state_q   <= S_DIV;
				end
				S_F9: begin
					dvd_q     <= 65'(d_f9) + 65'({blocks_q, 7'd0});
					rem_q     <= 33'd0;
					dvs_q     <= {blocks_q, 8'd0};
					dcnt_q    <= 7'd65;
					div_ret_q <= S_F10;
					state_q   <= S_DIV;
				end
				S_F10: begin
					if (dvd_q > 65'(VARIANCE_MAX)) begin
						var_q <= VARIANCE_MAX;
					end else begin
						var_q <= dvd_q[28:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					done_q                <= 1'b1;
					result_q.variance     <= var_q;
					result_q.mean_entropy <= mean_q;
					result_q.block_total  <= blocks_q;
					result_q.overflow     <= ovf_q;
					blocks_q              <= 25'd0;
					esum_q                <= 44'd0;
					esq_q                 <= 64'd0;
					ovf_q                 <= 1'b0;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BEV_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`BEV_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`BEV_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`BEV_ASSERT_SAME(a_var_bound, clk, arst_n, done, result.variance <= VARIANCE_MAX)

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import bev_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	bev_req_t    req;
	logic        done;
	bev_res_t    result;
	logic        cfg_we;
	logic [16:0] cfg_wdata;

	block_entropy_variance_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned CLOSE_WAIT = 12000;

	typedef struct {
		logic [7:0] byte_value;
		logic       last;
		bit         typed;
		bev_res_t   stats;
	} stim_row_t;

	logic [16:0]     blk_size;
	int unsigned     hist [BINS];
	int unsigned     fill;
	int unsigned     nblk;
	longint unsigned hsum;
	longint unsigned hsq;
	bit              ovf;

	bev_res_t    expected_stats [$];
	int unsigned errors;
	int unsigned stats_seen;
	int unsigned bytes_sent;
	int unsigned cycles;
	int          burst_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned log2_fix(input int unsigned x);
		int unsigned     e;
		int unsigned     r;
		longint unsigned m;
		e = 0;
		if (x == 0) begin
			return 0;
		end
		while (e < 31 && (x >> (e + 1)) != 0) begin
			e++;
		end
		m = longint'(x) << (30 - e);
		r = e << 16;
		for (int i = 16; i > 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				r = r | (32'd1 << (i - 1));
			end
		end
		return r;
	endfunction

	function automatic int unsigned block_entropy_of(input int unsigned n);
		longint unsigned s;
		longint unsigned avg;
		longint unsigned ln;
		s = 0;
		if (n == 0) begin
			return 0;
		end
		for (int i = 0; i < BINS; i++) begin
			if (hist[i] != 0) begin
				s += longint'(hist[i]) * log2_fix(hist[i]);
			end
		end
		avg = (s + n / 2) / n;
		ln = log2_fix(n);
		if (avg >= ln) begin
			return 0;
		end
		if (ln - avg > ENTROPY_MAX) begin
			return ENTROPY_MAX;
		end
		return int'(ln - avg);
	endfunction

	function automatic void close_entropy_block();
		longint unsigned h;
		longint unsigned sq;
		h = block_entropy_of(fill);
		sq = h * h;
		foreach (hist[i]) begin
			hist[i] = 0;
		end
		fill = 0;
		if (nblk >= BLOCKS_MAX) begin
			ovf = 1'b1;
			return;
		end
		nblk++;
		hsum += h;
		if (hsq > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
			hsq = 64'hFFFF_FFFF_FFFF_FFFF;
			ovf = 1'b1;
		end else begin
			hsq += sq;
		end
	endfunction

	function automatic void clear_stream_stats();
		foreach (hist[i]) begin
			hist[i] = 0;
		end
		fill = 0;
		nblk = 0;
		hsum = 0;
		hsq = 0;
		ovf = 1'b0;
	endfunction

	// Returns 1 when the byte ends a stream and so yields statistics.
	function automatic bit predict_stats(input bev_req_t r, output bev_res_t s);
		bit              whole;
		int unsigned     eff;
		longint unsigned n, q, rm, d, sub, var_v, mean;
		whole = (blk_size == 0 || blk_size > BYTES_MAX);
		eff = whole ? BYTES_MAX : blk_size;
		hist[r.byte_value]++;
		fill++;
		if (fill >= eff) begin
			if (whole && !r.last) begin
				ovf = 1'b1;
			end
			close_entropy_block();
		end else if (r.last) begin
			close_entropy_block();
		end
		if (!r.last) begin
			return 1'b0;
		end
		n = nblk;
		if (n == 0) begin
			var_v = 0;
			mean = 0;
		end else begin
			q = hsum / n;
			rm = hsum % n;
			mean = (hsum + n / 2) / n;
			d = hsq;
			sub = q * q * n;
			d = (d > sub) ? d - sub : 0;
			sub = 2 * q * rm;
			d = (d > sub) ? d - sub : 0;
			sub = (rm * rm + n / 2) / n;
			d = (d > sub) ? d - sub : 0;
			var_v = (d + 128 * n) / (256 * n);
			if (var_v > VARIANCE_MAX) begin
				var_v = VARIANCE_MAX;
			end
		end
		s.variance = var_v[28:0];
		s.mean_entropy = mean[19:0];
		s.block_total = n[24:0];
		s.overflow = ovf;
		clear_stream_stats();
		return 1'b1;
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
			input bev_res_t typed_stats, input bit bursty);
		bev_req_t r;
		bev_res_t s;
		if (bursty) begin
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
			burst_left--;
		end
		r.byte_value = b;
		r.last = l;
		start <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
		end while (busy);
		@(posedge clk);
		bytes_sent++;
		if (predict_stats(r, s)) begin
			expected_stats.push_back(typed ? typed_stats : s);
		end
	endtask

	task automatic write_chunk_len(input logic [16:0] v);
		start <= 1'b0;
		wait (expected_stats.size() == 0);
		@(posedge clk);
		repeat (20) @(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		blk_size = v;
	endtask

	task automatic random_streams(input int unsigned total, input int unsigned max_len);
		int unsigned len;
		int unsigned sent;
		int unsigned alphabet;
		sent = 0;
		while (sent < total) begin
			len = $urandom_range(1, max_len);
			alphabet = 1 << $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				send_byte(8'($urandom_range(0, alphabet - 1) ^ ($urandom_range(0, 1) ? 8'hFF : 8'h00)),
					(i == len - 1), 1'b0, '0, 1'b1);
			end
			sent += len;
		end
	endtask

	always @(negedge clk) begin
		bev_res_t e;
		if (arst_n && done) begin
			stats_seen++;
			if (expected_stats.size() == 0) begin
				$error("statistics returned with none expected");
				errors++;
			end else begin
				e = expected_stats.pop_front();
				if (result.variance !== e.variance) begin
					$error("variance: expected %0d, got %0d", e.variance, result.variance);
					errors++;
				end
				if (result.mean_entropy !== e.mean_entropy) begin
					$error("mean_entropy: expected %0d, got %0d", e.mean_entropy,
						result.mean_entropy);
					errors++;
				end
				if (result.block_total !== e.block_total) begin
					$error("block_total: expected %0d, got %0d", e.block_total,
						result.block_total);
					errors++;
				end
				if (result.overflow !== e.overflow) begin
					$error("overflow: expected %0d, got %0d", e.overflow, result.overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	stim_row_t directed [25] = '{
		'{8'h00, 1'b1, 1'b1, '{29'd0, 20'd0, 25'd1, 1'b0}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, '{29'd0, 20'd65536, 25'd1, 1'b0}},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'hFE, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hAA, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		'{8'h03, 1'b0, 1'b0, '0},
		'{8'h04, 1'b0, 1'b0, '0},
		'{8'h05, 1'b0, 1'b0, '0},
		'{8'h06, 1'b0, 1'b0, '0},
		'{8'h07, 1'b0, 1'b0, '0},
		'{8'h08, 1'b0, 1'b0, '0},
		'{8'h09, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b0, 1'b0, '0},
		'{8'h0B, 1'b0, 1'b0, '0},
		'{8'h0C, 1'b0, 1'b0, '0},
		'{8'h0D, 1'b0, 1'b0, '0},
		'{8'h0E, 1'b0, 1'b0, '0},
		'{8'h0F, 1'b1, 1'b1, '{29'd0, 20'd262144, 25'd1, 1'b0}}
	};

	logic [16:0] sizes [8] = '{17'd1, 17'd3, 17'd65536, 17'd0, 17'd131071, 17'd7, 17'd2, 17'd16};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		stats_seen = 0;
		bytes_sent = 0;
		cycles = 0;
		burst_left = 0;
		blk_size = CHUNK_LEN_RESET;
		clear_stream_stats();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i].byte_value, directed[i].last, directed[i].typed,
				directed[i].stats, 1'b0);
		end

		foreach (sizes[k]) begin
			write_chunk_len(sizes[k]);
			random_streams((sizes[k] == 17'd1) ? 100 : 140, 40);
		end
		write_chunk_len(17'($urandom_range(4, 64)));
		random_streams(120, 200);

		// Bytes with no end of stream produce nothing.
		write_chunk_len(17'd5);
		for (int i = 0; i < 12; i++) begin
			send_byte(8'($urandom), 1'b0, 1'b0, '0, 1'b1);
		end
		start <= 1'b0;

		wait (expected_stats.size() == 0);
		repeat (CLOSE_WAIT) @(posedge clk);
		$display("Sent %0d bytes across short, whole-stream and random block lengths.",
			bytes_sent);
		$display("%0d statistics results were compared with the predictor.", stats_seen);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
